### rtl/lidar_point_camera_projector_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lidar point camera projector
// Immediate-consequence and next-cycle property wrappers.
// ----------------------------------------------------------------------------
`ifndef LIDAR_POINT_CAMERA_PROJECTOR_ASSERT_SVH
`define LIDAR_POINT_CAMERA_PROJECTOR_ASSERT_SVH

`define LPCP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`define LPCP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/lpcp_pkg.sv
// ----------------------------------------------------------------------------
// lpcp_pkg
// Widths, item types and register codes of the point projector.
// ----------------------------------------------------------------------------
package lpcp_pkg;

    localparam int COORD_BITS = 24;
    localparam int PIXEL_BITS = 12;
    localparam int CAM_W      = COORD_BITS + 12;
    localparam int ACC_W      = COORD_BITS + 18;
    localparam int NUM_W      = CAM_W + 18;
    localparam int DEN_W      = CAM_W + 4;
    localparam int REM_W      = NUM_W + PIXEL_BITS;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_ROT_ONE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_TWO   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_THREE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANS     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PRINCIPAL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 3'd7;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] point_x;
        logic signed [COORD_BITS-1:0] point_y;
        logic signed [COORD_BITS-1:0] point_z;
    } in_item_t;

    typedef struct packed {
        logic [PIXEL_BITS-1:0] pixel_column;
        logic [PIXEL_BITS-1:0] pixel_row;
        logic                  in_image;
    } out_item_t;

    typedef struct packed {
        logic             valid;
        logic             depth_ok;
        logic             col_ok;
        logic             row_ok;
        logic [DEN_W-1:0] den;
    } div_ctrl_t;

endpackage

### rtl/lpcp_xform.sv
// ----------------------------------------------------------------------------
// lpcp_xform
// Two-stage rigid transform: nine products, then the sums with the translation.
// ----------------------------------------------------------------------------
module lpcp_xform
    import lpcp_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     adv,
    input  logic                     in_valid,
    input  in_item_t                 in_item,
    input  logic [47:0]              rot [3],
    input  logic [47:0]              trans,
    output logic                     cam_valid,
    output logic signed [CAM_W-1:0]  cam [3]
);

    logic signed [COORD_BITS+15:0] prod_reg [9];
    logic signed [COORD_BITS+15:0] prod_next [9];
    logic                          a_valid_reg;
    logic signed [CAM_W-1:0]       cam_reg [3];
    logic signed [CAM_W-1:0]       cam_next [3];
    logic                          b_valid_reg;
    logic signed [COORD_BITS-1:0]  pt [3];

    assign pt[0] = in_item.point_x;
    assign pt[1] = in_item.point_y;
    assign pt[2] = in_item.point_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                prod_next[3*i+j] = $signed(rot[i][16*j +: 16]) * pt[j];
            end
        end
    end

    always_comb
    begin
        logic signed [ACC_W-1:0] acc;
        for (int i = 0; i < 3; i++)
        begin
            acc = ACC_W'($signed(trans[16*i +: 16])) <<< 14;
            for (int j = 0; j < 3; j++)
            begin
                acc = acc + ACC_W'(prod_reg[3*i+j]);
            end
            cam_next[i] = CAM_W'(acc >>> 6);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
            cam_reg  <= cam_next;
        end
    end

    assign cam_valid = b_valid_reg;
    assign cam       = cam_reg;

endmodule

### rtl/lpcp_div.sv
// ----------------------------------------------------------------------------
// lpcp_div
// One restoring division step for both pixel lanes, quotient bit BIT.
// ----------------------------------------------------------------------------
module lpcp_div
    import lpcp_pkg::*;
#(
    parameter int BIT = 0
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  div_ctrl_t             ctrl_in,
    input  logic [REM_W-1:0]      rem_col_in,
    input  logic [REM_W-1:0]      rem_row_in,
    input  logic [PIXEL_BITS-1:0] q_col_in,
    input  logic [PIXEL_BITS-1:0] q_row_in,
    output div_ctrl_t             ctrl_out,
    output logic [REM_W-1:0]      rem_col_out,
    output logic [REM_W-1:0]      rem_row_out,
    output logic [PIXEL_BITS-1:0] q_col_out,
    output logic [PIXEL_BITS-1:0] q_row_out
);

    div_ctrl_t             ctrl_reg;
    logic [REM_W-1:0]      rem_col_reg, rem_col_next;
    logic [REM_W-1:0]      rem_row_reg, rem_row_next;
    logic [PIXEL_BITS-1:0] q_col_reg, q_col_next;
    logic [PIXEL_BITS-1:0] q_row_reg, q_row_next;
    logic [REM_W-1:0]      den_sh;

    assign den_sh = REM_W'(ctrl_in.den) << BIT;

    always_comb
    begin
        rem_col_next = rem_col_in;
        rem_row_next = rem_row_in;
        q_col_next   = q_col_in;
        q_row_next   = q_row_in;
        if (rem_col_in >= den_sh)
        begin
            rem_col_next   = rem_col_in - den_sh;
            q_col_next[BIT] = 1'b1;
        end
        if (rem_row_in >= den_sh)
        begin
            rem_row_next   = rem_row_in - den_sh;
            q_row_next[BIT] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else if (adv)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rem_col_reg       <= rem_col_next;
            rem_row_reg       <= rem_row_next;
            q_col_reg         <= q_col_next;
            q_row_reg         <= q_row_next;
        end
    end

    assign ctrl_out    = ctrl_reg;
    assign rem_col_out = rem_col_reg;
    assign rem_row_out = rem_row_reg;
    assign q_col_out   = q_col_reg;
    assign q_row_out   = q_row_reg;

endmodule

### rtl/lidar_point_camera_projector.sv
// Path: transform, numerator, division-setup, division-step and output registers.
// Throughput: one point per cycle; the whole pipeline advances when the output
// register is empty or its item is taken.
// Reset: asynchronous, active low; clears valid bits and loads the identity
// projection for a 1280 x 720 camera.
// ----------------------------------------------------------------------------
// lidar_point_camera_projector
// Transform, pinhole numerators, bit-per-stage division and bounds check.
// ----------------------------------------------------------------------------
`include "lidar_point_camera_projector_assert.svh"

module lidar_point_camera_projector
    import lpcp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_item
);

    logic [47:0] rot_reg [3];
    logic [47:0] trans_reg;
    logic [31:0] focal_reg;
    logic [31:0] principal_reg;
    logic [23:0] size_reg;
    logic        adv;

    assign adv       = !out_valid || out_ready;
    assign in_ready  = adv;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rot_reg[0]    <= 48'd16384;
            rot_reg[1]    <= 48'd1073741824;
            rot_reg[2]    <= 48'd70368744177664;
            trans_reg     <= 48'd0;
            focal_reg     <= 32'd674900026;
            principal_reg <= 32'd381757472;
            size_reg      <= 24'd2950400;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ROT_ONE:   rot_reg[0]    <= cfg_data;
                CFG_ROT_TWO:   rot_reg[1]    <= cfg_data;
                CFG_ROT_THREE: rot_reg[2]    <= cfg_data;
                CFG_TRANS:     trans_reg     <= cfg_data;
                CFG_FOCAL:     focal_reg     <= cfg_data[31:0];
                CFG_PRINCIPAL: principal_reg <= cfg_data[31:0];
                CFG_SIZE:      size_reg      <= cfg_data[23:0];
                default:       ;
            endcase
        end
    end

    logic                    cam_valid;
    logic signed [CAM_W-1:0] cam [3];

    lpcp_xform u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .rot       (rot_reg),
        .trans     (trans_reg),
        .cam_valid (cam_valid),
        .cam       (cam)
    );

    logic                    n_valid_reg;
    logic signed [NUM_W-1:0] num_col_reg, num_row_reg;
    logic [DEN_W-1:0]        den_reg;
    logic                    depth_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            n_valid_reg <= cam_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            num_col_reg  <= NUM_W'($signed({1'b0, principal_reg[15:0]}) * cam[0])
                          - NUM_W'($signed({1'b0, focal_reg[15:0]}) * cam[1]);
            num_row_reg  <= NUM_W'($signed({1'b0, principal_reg[31:16]}) * cam[0])
                          - NUM_W'($signed({1'b0, focal_reg[31:16]}) * cam[2]);
            den_reg      <= DEN_W'(cam[0]) << 4;
            depth_ok_reg <= cam[0] > 0;
        end
    end

    div_ctrl_t             ctrl [PIXEL_BITS+1];
    logic [REM_W-1:0]      rem_col [PIXEL_BITS+1];
    logic [REM_W-1:0]      rem_row [PIXEL_BITS+1];
    logic [PIXEL_BITS-1:0] q_col [PIXEL_BITS+1];
    logic [PIXEL_BITS-1:0] q_row [PIXEL_BITS+1];
    logic [NUM_W-1:0]      mag_col, mag_row;
    logic [REM_W-1:0]      den_top, den_one;
    logic                  p_valid_reg, p_depth_reg, p_col_ok_reg, p_row_ok_reg;
    logic [DEN_W-1:0]      p_den_reg;
    logic [REM_W-1:0]      p_rem_col_reg, p_rem_row_reg;

    assign mag_col = num_col_reg[NUM_W-1] ? NUM_W'(-num_col_reg) : NUM_W'(num_col_reg);
    assign mag_row = num_row_reg[NUM_W-1] ? NUM_W'(-num_row_reg) : NUM_W'(num_row_reg);
    assign den_top = REM_W'(den_reg) << PIXEL_BITS;
    assign den_one = REM_W'(den_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p_valid_reg <= n_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p_depth_reg   <= depth_ok_reg;
            p_col_ok_reg  <= (REM_W'(mag_col) < den_top)
                           && (!num_col_reg[NUM_W-1] || REM_W'(mag_col) < den_one);
            p_row_ok_reg  <= (REM_W'(mag_row) < den_top)
                           && (!num_row_reg[NUM_W-1] || REM_W'(mag_row) < den_one);
            p_den_reg     <= den_reg;
            p_rem_col_reg <= REM_W'(mag_col);
            p_rem_row_reg <= REM_W'(mag_row);
        end
    end

    assign ctrl[0]    = '{valid: p_valid_reg, depth_ok: p_depth_reg, col_ok: p_col_ok_reg,
                          row_ok: p_row_ok_reg, den: p_den_reg};
    assign rem_col[0] = p_rem_col_reg;
    assign rem_row[0] = p_rem_row_reg;
    assign q_col[0]   = '0;
    assign q_row[0]   = '0;

    for (genvar s = 0; s < PIXEL_BITS; s++)
    begin : g_div
        lpcp_div #(
            .BIT (PIXEL_BITS - 1 - s)
        ) u_div (
            .clk         (clk),
            .rst_n       (rst_n),
            .adv         (adv),
            .ctrl_in     (ctrl[s]),
            .rem_col_in  (rem_col[s]),
            .rem_row_in  (rem_row[s]),
            .q_col_in    (q_col[s]),
            .q_row_in    (q_row[s]),
            .ctrl_out    (ctrl[s+1]),
            .rem_col_out (rem_col[s+1]),
            .rem_row_out (rem_row[s+1]),
            .q_col_out   (q_col[s+1]),
            .q_row_out   (q_row[s+1])
        );
    end

    div_ctrl_t             fin;
    logic                  in_bounds;
    logic                  out_valid_reg;
    out_item_t             out_item_reg;

    assign fin       = ctrl[PIXEL_BITS];
    assign in_bounds = fin.depth_ok && fin.col_ok && fin.row_ok
                    && (q_col[PIXEL_BITS] < size_reg[PIXEL_BITS-1:0])
                    && (q_row[PIXEL_BITS] < size_reg[2*PIXEL_BITS-1:PIXEL_BITS]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= fin.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_item_reg.pixel_column <= in_bounds ? q_col[PIXEL_BITS] : '0;
            out_item_reg.pixel_row    <= in_bounds ? q_row[PIXEL_BITS] : '0;
            out_item_reg.in_image     <= in_bounds;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `LPCP_ASSERT_NOW(a_outside_zero, out_valid && !out_item.in_image,
        out_item.pixel_column == '0 && out_item.pixel_row == '0)
    `LPCP_ASSERT_NOW(a_ready_follows_out, 1'b1, in_ready == (!out_valid || out_ready))
    `LPCP_ASSERT_NEXT(a_stall_holds_div, !adv, $stable(q_col[PIXEL_BITS]) && $stable(fin))

endmodule
